### rtl/core/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared constants, types and helpers for the frame presentation pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpp_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int TIME_W = 31;
  localparam int TAG_W  = 8;
  localparam int NOW_W  = 32;
  localparam int ENT_W  = TIME_W + TAG_W;
  localparam int LIM_W  = NOW_W + 2;

  // item kinds
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_PERIOD = 3'd1;
  localparam logic [2:0] CFG_SLACK  = 3'd2;
  localparam logic [2:0] CFG_LOOP   = 3'd3;
  localparam logic [2:0] CFG_STALL  = 3'd4;

  localparam logic [6:0] PERIOD_MIN = 7'd8;
  localparam logic [6:0] PERIOD_MAX = 7'd100;

  typedef struct packed {
    logic [TAG_W-1:0]  frame_tag;
    logic [TIME_W-1:0] frame_time_ms;
    logic [NOW_W-1:0]  now_ms;
    logic [1:0]        op;
  } item_t;

  typedef struct packed {
    logic [4:0]        fill;
    logic [4:0]        skipped;
    logic [TIME_W-1:0] shown_time_ms;
    logic [TAG_W-1:0]  shown_tag;
    logic              presented;
    logic              push_accepted;
  } result_t;

  typedef struct packed {
    logic        fixed_period_mode;
    logic [6:0]  period;          // clamped to 8..100
    logic [7:0]  due_slack_ms;
    logic [15:0] loop_jump_ms;
    logic [15:0] stall_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [FILL_W-1:0] fill;
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fpp_ram.sv
// ----------------------------------------------------------------------------
// fpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/fpp_cfg.sv
// ----------------------------------------------------------------------------
// fpp_cfg
// Configuration register file; period is clamped on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_cfg
  import fpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output      cfg_t        cfg
);

  logic        mode;
  logic [6:0]  period;
  logic [7:0]  slack;
  logic [15:0] loop_jump;
  logic [15:0] stall_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      period      <= 7'd33;
      slack       <= 8'd5;
      loop_jump   <= 16'd500;
      stall_limit <= 16'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:   mode        <= cfg_data[0];
        CFG_PERIOD: period      <= cfg_data[6:0];
        CFG_SLACK:  slack       <= cfg_data[7:0];
        CFG_LOOP:   loop_jump   <= cfg_data;
        CFG_STALL:  stall_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.fixed_period_mode = mode;
    if (period < PERIOD_MIN)      cfg.period = PERIOD_MIN;
    else if (period > PERIOD_MAX) cfg.period = PERIOD_MAX;
    else                          cfg.period = period;
    cfg.due_slack_ms   = slack;
    cfg.loop_jump_ms   = loop_jump;
    cfg.stall_limit_ms = stall_limit;
  end

endmodule

`default_nettype wire

### rtl/core/fpp_seq.sv
// ----------------------------------------------------------------------------
// fpp_seq
// Frame queue in RAM plus the pacing sequencer (push, tick, restart).
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_seq
  import fpp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output      logic    in_ready,
  input  wire item_t   in_item,
  output      logic    res_valid,
  input  wire logic    res_ready,
  output      result_t res,
  output      status_t status
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_FX_DO   = 9'b000000100,
    S_FX_FIX  = 9'b000001000,
    S_TS_REB  = 9'b000010000,
    S_TS_LIM  = 9'b000100000,
    S_TS_EVAL = 9'b001000000,
    S_TS_CHK1 = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t state;

  logic [PTR_W-1:0]  head_ptr, tail_ptr;
  logic [FILL_W-1:0] fill_count;
  logic [NOW_W-1:0]  start_time, previous_tick, next_release;
  logic [TIME_W-1:0] last_shown_time;
  logic              last_shown_valid;

  // payload
  item_t             item;
  logic [TIME_W-1:0] h_time;
  logic [TAG_W-1:0]  h_tag;
  logic [LIM_W-1:0]  limit;
  logic              r_acc, r_pres;
  logic [TAG_W-1:0]  r_tag;
  logic [TIME_W-1:0] r_time;
  logic [FILL_W-1:0] r_skip;

  // queue RAM: {tag, time}
  logic              ram_we;
  logic [PTR_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [TIME_W-1:0] rd_time;
  logic [TAG_W-1:0]  rd_tag;

  assign rd_time   = ram_rdata[TIME_W-1:0];
  assign rd_tag    = ram_rdata[ENT_W-1:TIME_W];
  assign ram_we    = (state == S_EXEC) && (item.op == OP_PUSH) &&
                     (fill_count < FILL_W'(DEPTH));
  assign ram_raddr = (state == S_TS_EVAL) ? ptr_inc(head_ptr) : head_ptr;

  fpp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata ({item.frame_tag, item.frame_time_ms}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // arithmetic terms
  logic             stall_gap;
  logic [NOW_W-1:0] nr_a, nr_b;
  logic             fx_due;
  logic             loop_hit;
  logic [NOW_W:0]   rel;
  logic             h_due, n_due;

  always_comb begin
    stall_gap = (previous_tick != '0) &&
                ((item.now_ms - previous_tick) > NOW_W'(cfg.stall_limit_ms));
    nr_a      = stall_gap ? item.now_ms : next_release;
    nr_b      = (nr_a == '0) ? item.now_ms : nr_a;
    fx_due    = (fill_count != '0) &&
                ((item.now_ms + NOW_W'(cfg.due_slack_ms)) >= next_release);
    loop_hit  = last_shown_valid &&
                (({1'b0, rd_time} + 32'(cfg.loop_jump_ms)) < {1'b0, last_shown_time});
    rel       = {1'b0, item.now_ms} - {1'b0, start_time};
    h_due     = $signed({3'b000, h_time}) <= $signed(limit);
    n_due     = $signed({3'b000, rd_time}) <= $signed(limit);
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign status    = '{head: head_ptr, tail: tail_ptr, fill: fill_count};

  always_comb begin
    res.push_accepted = r_acc;
    res.presented     = r_pres;
    res.shown_tag     = r_pres ? r_tag  : '0;
    res.shown_time_ms = r_pres ? r_time : '0;
    res.skipped       = 5'(r_skip);
    res.fill          = 5'(fill_count);
  end

  // control and timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      head_ptr         <= '0;
      tail_ptr         <= '0;
      fill_count       <= '0;
      start_time       <= '0;
      previous_tick    <= '0;
      next_release     <= '0;
      last_shown_time  <= '0;
      last_shown_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_OUT;
          case (item.op)
            OP_PUSH: begin
              if (ram_we) begin
                tail_ptr   <= ptr_inc(tail_ptr);
                fill_count <= fill_count + 1'b1;
              end
            end
            OP_TICK: begin
              if (cfg.fixed_period_mode) begin
                previous_tick <= item.now_ms;
                next_release  <= nr_b;
                state         <= S_FX_DO;
              end else if (fill_count != '0) begin
                state <= S_TS_REB;
              end
            end
            OP_RESTART: begin
              start_time       <= item.now_ms;
              last_shown_valid <= 1'b0;
              previous_tick    <= cfg.fixed_period_mode ? item.now_ms : '0;
              next_release     <= cfg.fixed_period_mode ? item.now_ms : '0;
              if (!cfg.fixed_period_mode) begin
                head_ptr   <= '0;
                tail_ptr   <= '0;
                fill_count <= '0;
              end
            end
            default: ;
          endcase
        end
        S_FX_DO: begin
          if (fx_due) begin
            head_ptr         <= ptr_inc(head_ptr);
            fill_count       <= fill_count - 1'b1;
            last_shown_time  <= rd_time;
            last_shown_valid <= 1'b1;
            next_release     <= next_release + NOW_W'(cfg.period);
            state            <= S_FX_FIX;
          end else begin
            state <= S_OUT;
          end
        end
        S_FX_FIX: begin
          // fell too far behind: restart the schedule from now
          if (item.now_ms > (next_release + NOW_W'(cfg.stall_limit_ms)))
            next_release <= item.now_ms + NOW_W'(cfg.period);
          state <= S_OUT;
        end
        S_TS_REB: begin
          // stream looped: rebase so the head lands on now
          if (loop_hit) begin
            start_time       <= item.now_ms - NOW_W'(rd_time);
            last_shown_valid <= 1'b0;
          end
          state <= S_TS_LIM;
        end
        S_TS_LIM: begin
          state <= S_TS_EVAL;
        end
        S_TS_EVAL: begin
          if (!h_due) begin
            state <= S_OUT;
          end else if (fill_count >= FILL_W'(2)) begin
            state <= S_TS_CHK1;
          end else begin
            head_ptr         <= ptr_inc(head_ptr);
            fill_count       <= fill_count - 1'b1;
            last_shown_time  <= h_time;
            last_shown_valid <= 1'b1;
            state            <= S_OUT;
          end
        end
        S_TS_CHK1: begin
          head_ptr   <= ptr_inc(head_ptr);
          fill_count <= fill_count - 1'b1;
          if (n_due) begin
            state <= S_TS_EVAL;
          end else begin
            last_shown_time  <= h_time;
            last_shown_valid <= 1'b1;
            state            <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_item;
    if (state == S_EXEC) begin
      r_acc  <= ram_we;
      r_pres <= 1'b0;
      r_skip <= '0;
    end
    if (state == S_FX_DO && fx_due) begin
      r_pres <= 1'b1;
      r_tag  <= rd_tag;
      r_time <= rd_time;
    end
    if (state == S_TS_REB) begin
      h_time <= rd_time;
      h_tag  <= rd_tag;
    end
    if (state == S_TS_LIM) limit <= {rel[NOW_W], rel} + LIM_W'(cfg.due_slack_ms);
    if (state == S_TS_EVAL && h_due && fill_count < FILL_W'(2)) begin
      r_pres <= 1'b1;
      r_tag  <= h_tag;
      r_time <= h_time;
    end
    if (state == S_TS_CHK1) begin
      if (n_due) begin
        // head is overdue and its successor is due: discard head
        r_skip <= r_skip + 1'b1;
        h_time <= rd_time;
        h_tag  <= rd_tag;
      end else begin
        r_pres <= 1'b1;
        r_tag  <= h_tag;
        r_time <= h_time;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/frame_presentation_pacer.sv
// ----------------------------------------------------------------------------
// frame_presentation_pacer
// Frame queue with timestamp or fixed-period presentation pacing.
// ----------------------------------------------------------------------------
// Path (accept to m_tvalid): push, restart and a timestamp tick on an empty
// queue pass S_EXEC and S_OUT; a fixed-period tick adds S_FX_DO, and S_FX_FIX
// when a frame is shown; a timestamp tick adds S_TS_REB, S_TS_LIM, S_TS_EVAL,
// and S_TS_CHK1 when the successor is checked, plus one S_TS_CHK1/S_TS_EVAL
// pass per discarded frame. One item in flight: s_tready returns with m_tvalid.
// Reset (rst, synchronous): queue empty, timing state zero, registers default.
`default_nettype none

module frame_presentation_pacer
  import fpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [71:0] s_tdata,  // now_ms, frame_time_ms, frame_tag
  input  wire logic [1:0]  s_tuser,  // op
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // push_accepted, presented, shown_tag, shown_time_ms, skipped, fill
  output      logic [55:0] m_tdata,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  result_t res;
  status_t status;
  logic    res_valid, res_ready;

  assign in_item.op            = s_tuser;
  assign in_item.now_ms        = s_tdata[31:0];
  assign in_item.frame_time_ms = s_tdata[62:32];
  assign in_item.frame_tag     = s_tdata[70:63];

  fpp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .status    (status)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) m_tdata <= {5'b0, res};
  end

  // queue bookkeeping: head + fill wraps onto tail
  logic [FILL_W:0] ht_sum, ht_wrap;

  always_comb begin
    ht_sum  = (FILL_W+1)'(status.head) + (FILL_W+1)'(status.fill);
    ht_wrap = (ht_sum >= (FILL_W+1)'(DEPTH)) ? ht_sum - (FILL_W+1)'(DEPTH) : ht_sum;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill <= FILL_W'(DEPTH))
    else $error("queue fill above depth");

  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(ht_wrap) == status.tail)
    else $error("head, tail and fill disagree");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_push_xor_show: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("result both enqueued and presented");

endmodule

`default_nettype wire
